// File: rtl/ctli_pkg.sv
// Shared constants for the clamped table linear interpolator.
// Field widths, fixed-point scale factors, action and register codes.
// No dependencies.
`default_nettype none

package ctli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 512;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int ADDR_W      = IDX_W + 1;          // table select on top of slot
  localparam int RAM_DEPTH   = 2 * TABLE_DEPTH;

  // Field widths
  localparam int ACT_W   = 2;
  localparam int ANGLE_W = 20;
  localparam int CFG_W   = 10;
  localparam int EIDX_W  = 9;
  localparam int ENTRY_W = 17;
  localparam int OUT_W   = 20;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_QUERY    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WR_LOWER = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WR_UPPER = 2'd2;

  // Configuration register indexes
  localparam logic CFG_LOW_DEG  = 1'b0;
  localparam logic CFG_HIGH_DEG = 1'b1;

  localparam logic signed [CFG_W-1:0] LOW_DEG_RST  = -10'sd180;
  localparam logic signed [CFG_W-1:0] HIGH_DEG_RST = 10'sd180;

  // round(180/pi * 2^20) and round(pi/180 * 2^32), as positive signed constants
  localparam logic signed [26:0] DEG_PER_RAD_Q20 = 27'sd60078979;
  localparam logic signed [27:0] RAD_PER_DEG_Q32 = 28'sd74961321;

  // Last valid slot, wide enough for any depth up to 4096
  localparam logic signed [13:0] LAST_SLOT = 14'(TABLE_DEPTH - 1);

  // Output saturation bounds on the 23-bit rounded result
  localparam logic signed [22:0] OUT_MAX = 23'sd524287;
  localparam logic signed [22:0] OUT_MIN = -23'sd524288;

endpackage

`default_nettype wire

// File: rtl/ctli_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data updates only when the read enable is high. No dependencies.
`default_nettype none

module ctli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/clamped_table_linear_interpolator.sv
// Top level of the clamped table linear interpolator.
// Depends on ctli_pkg and ctli_ram.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item: a query
//   (action 0) or a write of one lower or upper table entry (action 1 or 2).
//   Writes give no result; each query gives one beat on the output channel
//   (out_valid_o / out_stall_i) carrying limit_rad_o in radians, Q3.16.
//   Both tables live in two copies of one 2*TABLE_DEPTH entry RAM, so the two
//   neighboring entries of a query are read in the same cycle.
//   Throughput: one item per cycle while in_stall_o is low. A query passes, in
//   order, the degree multiply, RAM read, difference multiply, sum, two split
//   radian multiplies, and round and clamp before its result shows at out_valid_o.
//   A write lands in the RAM from the stage 1 registers, ahead of any query
//   accepted later.
//   When the receiver stalls, the output register holds and one more result
//   parks in a skid register; in_stall_o then rises and the pipeline freezes.
//   Reset empties the pipeline and loads the span registers with -180 and 180;
//   table contents are undefined until written.
//   Configuration writes (cfg_we_i) take effect at once; issue them only while
//   the block is idle.
`default_nettype none

module clamped_table_linear_interpolator
  import ctli_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic        [CFG_W-1:0]    cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic        [ACT_W-1:0]    action_i,
  input  wire logic signed [ANGLE_W-1:0]  angle_rad_i,
  input  wire logic                       use_lower_table_i,
  input  wire logic        [EIDX_W-1:0]   entry_index_i,
  input  wire logic signed [ENTRY_W-1:0]  entry_value_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed      [OUT_W-1:0]    limit_rad_o
);

  function automatic logic [IDX_W-1:0] slot_of(input logic signed [11:0] deg,
                                               input logic signed [11:0] lo,
                                               input logic signed [11:0] hi);
    logic signed [11:0] c;
    logic signed [13:0] off;
    c = deg;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    off = 14'(c) - 14'(lo);
    if (off < 14'sd0) off = 14'sd0;
    if (off > LAST_SLOT) off = LAST_SLOT;
    return off[IDX_W-1:0];
  endfunction

  // Configuration registers
  logic signed [CFG_W-1:0] low_deg_q, high_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_deg_q  <= LOW_DEG_RST;
      high_deg_q <= HIGH_DEG_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LOW_DEG) begin
        low_deg_q <= $signed(cfg_data_i);
      end else begin
        high_deg_q <= $signed(cfg_data_i);
      end
    end
  end

  // Flow control
  logic pipe_en, in_acc;
  logic skid_v_q;

  assign pipe_en    = !skid_v_q;
  assign in_stall_o = skid_v_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Stage 1: degree product
  logic signed [46:0] mul_deg;
  assign mul_deg = 47'(angle_rad_i) * 47'(DEG_PER_RAD_Q20);

  logic                      s1_v_q;
  logic [ACT_W-1:0]          s1_act_q;
  logic                      s1_sel_q;
  logic [EIDX_W-1:0]         s1_idx_q;
  logic signed [ENTRY_W-1:0] s1_val_q;
  logic [25:0]               s1_deg_q;   // degrees, Q16, floored

  // Stage 1 combinational: index, clamp, RAM access
  logic signed [11:0] n0, n1, lo12, hi12;
  logic [IDX_W-1:0]   slot0, slot1;
  logic               wr_item, wr_en;
  logic [ADDR_W-1:0]  waddr, raddr0, raddr1;
  logic [ENTRY_W-1:0] e0_raw, e1_raw;

  assign n0    = {{2{s1_deg_q[25]}}, s1_deg_q[25:16]};
  assign n1    = n0 + 12'sd1;
  assign lo12  = 12'(low_deg_q);
  assign hi12  = 12'(high_deg_q);
  assign slot0 = slot_of(n0, lo12, hi12);
  assign slot1 = slot_of(n1, lo12, hi12);

  assign raddr0  = {s1_sel_q, slot0};
  assign raddr1  = {s1_sel_q, slot1};
  assign wr_item = (s1_act_q == ACT_WR_LOWER) || (s1_act_q == ACT_WR_UPPER);
  // drop writes beyond the table
  assign wr_en   = pipe_en && s1_v_q && wr_item && (32'(s1_idx_q) < TABLE_DEPTH);
  assign waddr   = {s1_act_q == ACT_WR_LOWER, IDX_W'(s1_idx_q)};

  ctli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(s1_val_q),
    .re_i   (pipe_en),
    .raddr_i(raddr0),
    .rdata_o(e0_raw)
  );

  ctli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(waddr),
    .wdata_i(s1_val_q),
    .re_i   (pipe_en),
    .raddr_i(raddr1),
    .rdata_o(e1_raw)
  );

  // Stage 2: entries from RAM, difference times fraction
  logic        s2_v_q;
  logic [15:0] s2_frac_q;

  logic signed [17:0] diff;
  logic signed [34:0] mul_frac;
  assign diff     = 18'($signed(e1_raw)) - 18'($signed(e0_raw));
  assign mul_frac = 35'(diff) * 35'($signed({1'b0, s2_frac_q}));

  // Stage 3: interpolated value, degrees Q24
  logic                      s3_v_q;
  logic signed [34:0]        s3_prod_q;
  logic signed [ENTRY_W-1:0] s3_e0_q;

  logic signed [35:0] v_sum;
  assign v_sum = (36'(s3_e0_q) <<< 16) + 36'(s3_prod_q);

  // Stage 4: split radian multiply
  logic               s4_v_q;
  logic signed [16:0] s4_vh_q;
  logic [16:0]        s4_vl_q;

  logic signed [44:0] mul_hi;
  logic signed [45:0] mul_lo;
  assign mul_hi = 45'(s4_vh_q) * 45'(RAD_PER_DEG_Q32);
  assign mul_lo = 46'($signed({1'b0, s4_vl_q})) * 46'(RAD_PER_DEG_Q32);

  // Stage 5: recombine, round half up to Q16, saturate
  logic               s5_v_q;
  logic signed [44:0] s5_hi_q;
  logic signed [45:0] s5_lo_q;

  logic signed [62:0] p_rad;
  logic signed [22:0] r_round;
  logic signed [OUT_W-1:0] res;
  logic res_v;

  assign p_rad   = (63'(s5_hi_q) <<< 17) + 63'(s5_lo_q) + (63'sd1 <<< 39);
  assign r_round = p_rad[62:40];
  always_comb begin
    if (r_round > OUT_MAX) begin
      res = OUT_W'(OUT_MAX);
    end else if (r_round < OUT_MIN) begin
      res = OUT_W'(OUT_MIN);
    end else begin
      res = r_round[OUT_W-1:0];
    end
  end
  assign res_v = s5_v_q && pipe_en;

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (pipe_en) begin
      s1_v_q <= in_acc;
      s2_v_q <= s1_v_q && (s1_act_q == ACT_QUERY);
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (in_acc) begin
        s1_act_q <= action_i;
        s1_sel_q <= use_lower_table_i;
        s1_idx_q <= entry_index_i;
        s1_val_q <= entry_value_i;
        s1_deg_q <= mul_deg[45:20];
      end
      s2_frac_q <= s1_deg_q[15:0];
      s3_prod_q <= mul_frac;
      s3_e0_q   <= $signed(e0_raw);
      s4_vh_q   <= v_sum[33:17];
      s4_vl_q   <= v_sum[16:0];
      s5_hi_q   <= mul_hi;
      s5_lo_q   <= mul_lo;
    end
  end

  // Output register and skid
  logic                    out_v_q;
  logic signed [OUT_W-1:0] out_q, skid_q;
  logic                    out_ready;

  assign out_ready = !out_v_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_ready) begin
      out_v_q  <= skid_v_q || res_v;
      skid_v_q <= 1'b0;
    end else if (res_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      // drain the skid beat first; a new result only arrives when it is empty
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (res_v) begin
        out_q <= res;
      end
    end else if (res_v) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign limit_rad_o = out_q;

endmodule

`default_nettype wire

// File: sim/ctli_limit_checker.sv
// Scoreboard for the clamped table linear interpolator: mirrors both limit tables
// and the span registers, predicts each query beat and compares the output channel.
// Depends on ctli_pkg.
module ctli_limit_checker
  import ctli_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic        [CFG_W-1:0]   cfg_data_i,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic        [ACT_W-1:0]   action_i,
  input  logic signed [ANGLE_W-1:0] angle_rad_i,
  input  logic                      use_lower_table_i,
  input  logic        [EIDX_W-1:0]  entry_index_i,
  input  logic signed [ENTRY_W-1:0] entry_value_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic signed [OUT_W-1:0]   limit_rad_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [ENTRY_W-1:0] lower_store [TABLE_DEPTH];
  logic signed [ENTRY_W-1:0] upper_store [TABLE_DEPTH];
  logic signed [CFG_W-1:0]   span_low  = LOW_DEG_RST;
  logic signed [CFG_W-1:0]   span_high = HIGH_DEG_RST;
  logic signed [OUT_W-1:0]   limit_fifo [$];
  int                        fail_count = 0;
  int                        queued = 0;

  assign mismatch_count_o = fail_count;
  assign pending_o        = queued;

  task automatic report_mismatch(input string what);
    $display("[%0t] limit mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Clamp to the span first, then pin the offset into the table.
  function automatic int table_slot(input longint deg);
    longint c;
    c = deg;
    if (c < span_low) c = span_low;
    if (c > span_high) c = span_high;
    c = c - span_low;
    if (c < 0) c = 0;
    if (c > TABLE_DEPTH - 1) c = TABLE_DEPTH - 1;
    return int'(c);
  endfunction

  function automatic logic signed [OUT_W-1:0] interpolate_limit(
      input logic signed [ANGLE_W-1:0] angle, input logic lower);
    longint deg_q16, whole, frac, e0, e1, mix, rad;
    int     s0, s1;
    deg_q16 = (longint'(angle) * longint'(DEG_PER_RAD_Q20)) >>> 20;
    whole   = deg_q16 >>> 16;
    frac    = deg_q16 & longint'(16'hFFFF);
    s0 = table_slot(whole);
    s1 = table_slot(whole + 1);
    e0 = lower ? lower_store[s0] : upper_store[s0];
    e1 = lower ? lower_store[s1] : upper_store[s1];
    mix = e0 * (65536 - frac) + e1 * frac;
    // round half up from Q56 down to Q16
    rad = (mix * longint'(RAD_PER_DEG_Q32) + (longint'(1) <<< 39)) >>> 40;
    if (rad > OUT_MAX) rad = OUT_MAX;
    if (rad < OUT_MIN) rad = OUT_MIN;
    return rad[OUT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic signed [OUT_W-1:0] want;
    if (!rst_ni) begin
      span_low  = LOW_DEG_RST;
      span_high = HIGH_DEG_RST;
      limit_fifo.delete();
      queued = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (limit_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, limit_rad=%0d", limit_rad_i));
        end else begin
          want = limit_fifo.pop_front();
          if (limit_rad_i !== want)
            report_mismatch($sformatf("limit_rad got %0d want %0d", limit_rad_i, want));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_DEG:  span_low  = signed'(cfg_data_i);
          CFG_HIGH_DEG: span_high = signed'(cfg_data_i);
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ACT_QUERY: begin
            want       = interpolate_limit(angle_rad_i, use_lower_table_i);
            limit_fifo = {limit_fifo, want};
          end
          ACT_WR_LOWER: lower_store[entry_index_i] = entry_value_i;
          ACT_WR_UPPER: upper_store[entry_index_i] = entry_value_i;
          default: ;
        endcase
      end
      queued = limit_fifo.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// Testbench top for the clamped table linear interpolator: clock, reset, span
// settings and table/query traffic with random gaps and stalls.
// Depends on ctli_pkg, the interpolator RTL and ctli_limit_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ctli_pkg::*;

  localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;  // unused code, the block ignores it
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1620;
  localparam int PHASES       = 8;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic                      cfg_idx = CFG_LOW_DEG;
  logic        [CFG_W-1:0]   cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic        [ACT_W-1:0]   action = ACT_QUERY;
  logic signed [ANGLE_W-1:0] angle = '0;
  logic                      use_lower = 1'b0;
  logic        [EIDX_W-1:0]  entry_index = '0;
  logic signed [ENTRY_W-1:0] entry_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [OUT_W-1:0]   limit_rad;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  int stall_left = 0;
  int items_sent = 0;
  int span_lo = -180;
  int span_hi = 180;
  bit quiet = 1'b0;
  bit lower_written [TABLE_DEPTH];
  bit upper_written [TABLE_DEPTH];

  always #1 clk = ~clk;

  clamped_table_linear_interpolator dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .angle_rad_i      (angle),
    .use_lower_table_i(use_lower),
    .entry_index_i    (entry_index),
    .entry_value_i    (entry_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .limit_rad_o      (limit_rad)
  );

  ctli_limit_checker limit_scoreboard (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .angle_rad_i      (angle),
    .use_lower_table_i(use_lower),
    .entry_index_i    (entry_index),
    .entry_value_i    (entry_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .limit_rad_i      (limit_rad),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: after each taken beat hold stall for a random stall_left count, sometimes stall while empty.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = quiet ? 0 : $urandom_range(0, 4);
      out_stall <= (stall_left != 0);
    end else if (stall_left > 1) begin
      stall_left--;
    end else begin
      stall_left = 0;
      out_stall <= !quiet && ($urandom_range(0, 5) == 0);
    end
  end

  task automatic send_item(input logic [ACT_W-1:0] act, input logic signed [ANGLE_W-1:0] ang,
                           input logic lower, input logic [EIDX_W-1:0] idx,
                           input logic signed [ENTRY_W-1:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    angle       <= ang;
    use_lower   <= lower;
    entry_index <= idx;
    entry_value <= val;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [ENTRY_W-1:0] random_entry();
    if ($urandom_range(0, 4) == 0) return ENTRY_W'($urandom);
    return ENTRY_W'(int'($urandom_range(0, 92160)) - 46080);
  endfunction

  // Half full-range angles, half within a couple of degrees of the span.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int lo, hi, a;
    if ($urandom_range(0, 1) == 0) return ANGLE_W'($urandom);
    lo = (span_lo < span_hi ? span_lo : span_hi) - 2;
    hi = (span_lo < span_hi ? span_hi : span_lo) + 2;
    // roughly 1144 Q3.16 counts per degree
    a = (lo + int'($urandom_range(0, hi - lo))) * 1144 + int'($urandom_range(0, 1143));
    if (a > 524287) a = 524287;
    if (a < -524288) a = -524288;
    return ANGLE_W'(a);
  endfunction

  function automatic int slot_read_by(input longint deg);
    longint c;
    c = deg;
    if (c < span_lo) c = span_lo;
    if (c > span_hi) c = span_hi;
    c = c - span_lo;
    if (c < 0) c = 0;
    if (c > TABLE_DEPTH - 1) c = TABLE_DEPTH - 1;
    return int'(c);
  endfunction

  task automatic load_entry(input logic lower, input logic [EIDX_W-1:0] idx,
                            input logic signed [ENTRY_W-1:0] val);
    if (lower) lower_written[idx] = 1'b1;
    else upper_written[idx] = 1'b1;
    items_sent++;
    send_item(lower ? ACT_WR_LOWER : ACT_WR_UPPER, ANGLE_W'($urandom), 1'($urandom), idx, val);
  endtask

  // Load any neighbor entry not yet written, then query.
  task automatic ask_limit(input logic signed [ANGLE_W-1:0] ang, input logic lower);
    longint whole;
    int     s;
    whole = (longint'(ang) * longint'(DEG_PER_RAD_Q20)) >>> 36;
    for (int k = 0; k < 2; k++) begin
      s = slot_read_by(whole + k);
      if (lower ? !lower_written[s] : !upper_written[s])
        load_entry(lower, EIDX_W'(s), random_entry());
    end
    items_sent++;
    send_item(ACT_QUERY, ang, lower, EIDX_W'($urandom), ENTRY_W'($urandom));
  endtask

  task automatic send_noise();
    send_item(ACT_IDLE, ANGLE_W'($urandom), 1'($urandom), EIDX_W'($urandom),
              ENTRY_W'($urandom));
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_span(input int low, input int high);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LOW_DEG;
    cfg_data <= CFG_W'(low);
    @(posedge clk);
    cfg_idx  <= CFG_HIGH_DEG;
    cfg_data <= CFG_W'(high);
    @(posedge clk);
    cfg_we  <= 1'b0;
    span_lo = low;
    span_hi = high;
  endtask

  initial begin
    int phase_end, kind, low, high, pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table ends and value extremes under the reset span
    load_entry(1'b1, '0, ENTRY_W'(46080));
    load_entry(1'b0, '0, ENTRY_W'(-46080));
    load_entry(1'b1, EIDX_W'(TABLE_DEPTH - 1), ENTRY_W'(-65536));
    load_entry(1'b0, EIDX_W'(TABLE_DEPTH - 1), ENTRY_W'(65535));
    ask_limit('0, 1'b1);
    ask_limit(ANGLE_W'(-524288), 1'b0);
    ask_limit(ANGLE_W'(524287), 1'b1);
    send_noise();
    wait_drained(8);

    // span wider than the table: large offsets saturate at the last entry
    set_span(-512, 511);
    ask_limit(ANGLE_W'(524287), 1'b0);
    ask_limit(ANGLE_W'(-524288), 1'b1);
    wait_drained(8);

    // inverted span: clamp lands on the high bound, offset pins to entry zero
    set_span(100, -100);
    ask_limit(ANGLE_W'(524287), 1'b1);
    ask_limit(ANGLE_W'(-524288), 1'b0);
    wait_drained(8);

    set_span(511, 511);
    ask_limit(ANGLE_W'(-524288), 1'b1);
    wait_drained(8);
    set_span(-512, -512);
    ask_limit(ANGLE_W'(524287), 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained(8);
      kind = $urandom_range(0, 5);
      if (kind == 0) begin
        set_span(-512, 511);
      end else if (kind == 1) begin
        low = int'($urandom_range(0, 400)) - 200;
        set_span(low, low - int'($urandom_range(1, 200)));
      end else begin
        low  = int'($urandom_range(0, 900)) - 512;
        high = low + int'($urandom_range(0, 420));
        if (high > 511) high = 511;
        set_span(low, high);
      end
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) begin
        if (items_sent % 40 == 0) quiet <= ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 65) ask_limit(random_angle(), 1'($urandom));
        else if (pick < 95) load_entry(1'($urandom), EIDX_W'($urandom), random_entry());
        else send_noise();
      end
    end

    quiet <= 1'b0;
    wait_drained(20);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
rtl/ctli_pkg.sv
rtl/ctli_ram.sv
rtl/clamped_table_linear_interpolator.sv
sim/ctli_limit_checker.sv
sim/tb_top.sv
